>>> hdl/u8dec_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every module in hdl/.
package u8dec_pkg;

	localparam int BYTE_W    = 8;
	localparam int CP_W      = 21;
	localparam int LEN_W     = 3;
	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 2;

	localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
	localparam logic [CP_W-1:0] MIN_LEN2 = 21'h000080;
	localparam logic [CP_W-1:0] MIN_LEN3 = 21'h000800;
	localparam logic [CP_W-1:0] MIN_LEN4 = 21'h010000;

	localparam logic [LEN_W-1:0] LEN1 = 3'd1;
	localparam logic [LEN_W-1:0] LEN2 = 3'd2;
	localparam logic [LEN_W-1:0] LEN3 = 3'd3;
	localparam logic [LEN_W-1:0] LEN4 = 3'd4;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERLONG = 2'd1,
		ST_RANGE    = 2'd2,
		ST_BADLEAD  = 2'd3
	} status_t;

	// byte class as seen from idle
	typedef enum logic [2:0] {
		CLS_ASCII = 3'd0,
		CLS_CONT  = 3'd1,
		CLS_LEAD2 = 3'd2,
		CLS_LEAD3 = 3'd3,
		CLS_LEAD4 = 3'd4,
		CLS_BAD   = 3'd5
	} cls_t;

	typedef struct packed {
		cls_t              cls;
		logic [BYTE_W-1:0] data;
	} mid_item_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		status_t          status;
		logic [LEN_W-1:0] seq_length;
	} res_t;

endpackage

>>> hdl/u8dec_fifo.sv
// Small register-based request queue, used between front and back and at the output.
// Depends on u8dec_pkg.
module u8dec_fifo import u8dec_pkg::*; #(
	parameter int DEPTH = MID_DEPTH,
	parameter int WIDTH = $bits(mid_item_t)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/u8dec_front.sv
// Front end: takes input requests and classifies each byte by its lead pattern.
// Depends on u8dec_pkg; feeds the middle queue.
module u8dec_front import u8dec_pkg::*; (
	input  logic              push,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              full,
	input  logic              mid_full,
	output logic              mid_push,
	output mid_item_t         mid_item
);

	cls_t cls;

	always_comb begin
		priority casez (in_byte)
			8'b0???????: cls = CLS_ASCII;
			8'b10??????: cls = CLS_CONT;
			8'b110?????: cls = CLS_LEAD2;
			8'b1110????: cls = CLS_LEAD3;
			8'b11110???: cls = CLS_LEAD4;
			default:     cls = CLS_BAD;
		endcase
	end

	assign full          = mid_full;
	assign mid_push      = push;
	assign mid_item.cls  = cls;
	assign mid_item.data = in_byte;

endmodule

>>> hdl/u8dec_back.sv
// Back end: sequence state, code point assembly and overlong/range checks.
// Depends on u8dec_pkg; drains the middle queue into the result queue.
module u8dec_back import u8dec_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mid_item_t mid_item,
	input  logic      mid_empty,
	output logic      mid_pop,
	input  logic      out_full,
	output logic      out_push,
	output res_t      res
);

	logic [CP_W-1:0]  acc_q, acc_d, acc_shift, min_cp;
	logic [1:0]       rem_q, rem_d, rem_dec;
	logic [LEN_W-1:0] len_q, len_d;
	logic             emit;

	assign mid_pop   = !mid_empty && !out_full;
	assign out_push  = mid_pop && emit;
	assign acc_shift = {acc_q[CP_W-7:0], mid_item.data[5:0]};
	assign rem_dec   = rem_q - 2'd1;

	always_comb begin
		unique case (len_q)
			LEN2:    min_cp = MIN_LEN2;
			LEN3:    min_cp = MIN_LEN3;
			default: min_cp = MIN_LEN4;
		endcase
	end

	always_comb begin
		emit           = 1'b0;
		acc_d          = '0;
		rem_d          = '0;
		len_d          = '0;
		res.code_point = '0;
		res.status     = ST_OK;
		res.seq_length = LEN1;
		if (rem_q == 2'd0) begin
			unique case (mid_item.cls)
				CLS_ASCII: begin
					emit           = 1'b1;
					res.code_point = CP_W'(mid_item.data);
				end
				CLS_LEAD2: begin
					acc_d = CP_W'(mid_item.data[4:0]);
					rem_d = 2'd1;
					len_d = LEN2;
				end
				CLS_LEAD3: begin
					acc_d = CP_W'(mid_item.data[3:0]);
					rem_d = 2'd2;
					len_d = LEN3;
				end
				CLS_LEAD4: begin
					acc_d = CP_W'(mid_item.data[2:0]);
					rem_d = 2'd3;
					len_d = LEN4;
				end
				default: begin
					emit       = 1'b1;
					res.status = ST_BADLEAD;
				end
			endcase
		end else if (rem_dec != 2'd0) begin
			acc_d = acc_shift;
			rem_d = rem_dec;
			len_d = len_q;
		end else begin
			emit           = 1'b1;
			res.seq_length = len_q;
			if (acc_shift < min_cp) begin
				res.status = ST_OVERLONG;
			end else if (acc_shift > CP_MAX) begin
				res.status = ST_RANGE;
			end else begin
				res.code_point = acc_shift;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= '0;
			len_q <= '0;
		end else if (mid_pop) begin
			acc_q <= acc_d;
			rem_q <= rem_d;
			len_q <= len_d;
		end
	end

endmodule

>>> hdl/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder, top level.
// Depends on u8dec_pkg, u8dec_front, u8dec_fifo and u8dec_back.
//
// Input channel: one byte per request, accepted when push is high and full low.
// Result channel: queue style; while empty is low the oldest result sits on
// code_point/status/seq_length and is taken when pop is high.
// A byte below 0x80 or a bad lead gives one result; a 2/3/4-byte sequence
// gives one result on its last byte, nothing on the earlier ones.
// status: ok, overlong, above 0x10FFFF, invalid lead; code_point is zero
// unless ok. After every result the decoder is back at idle.
// Throughput: the back end takes one queued byte per cycle unless the result
// queue is full. A result shows in the cycle after its last byte is taken. A
// stalled receiver fills the result queue, then the middle queue, and full
// rises; nothing is dropped. Reset empties both queues and clears the
// sequence state; the first cycle after reset already accepts a byte.
module utf8_stream_decoder_unit import u8dec_pkg::*; #(
	parameter int MID_Q_DEPTH = MID_DEPTH,
	parameter int OUT_Q_DEPTH = OUT_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              empty,
	input  logic              pop,
	output logic [CP_W-1:0]   code_point,
	output logic [1:0]        status,
	output logic [LEN_W-1:0]  seq_length
);

	mid_item_t mid_wr, mid_rd;
	logic [$bits(mid_item_t)-1:0] mid_rdata;
	logic [$bits(res_t)-1:0]      out_rdata;
	logic      mid_push, mid_full, mid_pop, mid_empty;
	logic      out_push, out_full;
	res_t      res_wr, res_rd;

	u8dec_front u_front (
		.push     (push),
		.in_byte  (in_byte),
		.full     (full),
		.mid_full (mid_full),
		.mid_push (mid_push),
		.mid_item (mid_wr)
	);

	u8dec_fifo #(
		.DEPTH (MID_Q_DEPTH),
		.WIDTH ($bits(mid_item_t))
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wr),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign mid_rd = mid_item_t'(mid_rdata);

	u8dec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_item  (mid_rd),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.res       (res_wr)
	);

	u8dec_fifo #(
		.DEPTH (OUT_Q_DEPTH),
		.WIDTH ($bits(res_t))
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (res_wr),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign res_rd     = res_t'(out_rdata);
	assign code_point = res_rd.code_point;
	assign status     = res_rd.status;
	assign seq_length = res_rd.seq_length;

	a_ok_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_OK) |-> (code_point <= CP_MAX))
		else $error("ok result above scalar range");

	a_err_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != ST_OK) |-> (code_point == '0))
		else $error("error result with nonzero code point");

	a_badlead_len: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_BADLEAD) |-> (seq_length == LEN1))
		else $error("invalid lead with length other than one");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (seq_length >= LEN1 && seq_length <= LEN4))
		else $error("sequence length out of range");

	a_back_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_full |-> !mid_pop)
		else $error("back end consumed a byte while result queue full");

endmodule
